// ----- design/rls_pkg.sv -----
// ----------------------------------------------------------------------------
// rls_pkg: shared types and codes of the ratchet lift sequencer
// Action codes, mode codes, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package rls_pkg;

    localparam int RLS_POSITION_BITS = 32;
    localparam int RLS_TIMER_BITS    = 16;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = 32;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_KEEP_UP,
        ACT_CHECKING,
        ACT_DISENGAGING
    } rls_action_t;

    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_DOWN = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DOWN_SPEED         = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UP_SPEED           = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKTRACK_SPEED    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOP_LIMIT          = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKTRACK_DISTANCE = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECK_TIMEOUT      = 3'd5;

    typedef struct packed {
        logic signed [15:0] down_speed;
        logic signed [15:0] up_speed;
        logic signed [15:0] backtrack_speed;
        logic signed [31:0] top_limit;
        logic        [30:0] backtrack_distance;
        logic        [15:0] check_timeout;
    } rls_cfg_t;

    typedef struct packed {
        logic signed [15:0] motor_drive;
        logic               solenoid_on;
        rls_action_t        action;
    } rls_result_t;

endpackage

`default_nettype wire

// ----- design/rls_step.sv -----
// ----------------------------------------------------------------------------
// rls_step: one control period of the lock sequencer
// Motor speed, solenoid bit and next lock state from one request and state.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_step
    import rls_pkg::*;
#(
    parameter int POSITION_BITS = RLS_POSITION_BITS,
    parameter int TIMER_BITS    = RLS_TIMER_BITS
) (
    input  wire logic        [1:0]               mode,
    input  wire logic                            hung,
    input  wire logic                            lock_up,
    input  wire logic signed [POSITION_BITS-1:0] position,
    input  wire rls_cfg_t                        cfg,
    input  wire rls_action_t                     action_cur,
    input  wire logic        [TIMER_BITS-1:0]    ticks_cur,
    input  wire logic signed [POSITION_BITS-1:0] origin_cur,
    output rls_result_t                          result,
    output logic             [TIMER_BITS-1:0]    ticks_next,
    output logic signed      [POSITION_BITS-1:0] origin_next
);

    localparam int LIM_W  = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int DIST_W = (POSITION_BITS + 1 > 31) ? POSITION_BITS + 1 : 31;
    localparam int TICK_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic signed [LIM_W-1:0]       pos_lim;
    logic signed [LIM_W-1:0]       top_lim;
    logic                          below_top;
    logic signed [POSITION_BITS:0] diff;
    logic        [POSITION_BITS:0] travel;
    logic                          dist_reached;
    logic        [TICK_W-1:0]      ticks_cmp;
    logic        [TICK_W-1:0]      timeout_cmp;
    rls_action_t                   act;
    logic        [TIMER_BITS-1:0]  ticks;
    logic signed [15:0]            speed;
    logic                          sol;

    assign pos_lim   = LIM_W'(position);
    assign top_lim   = LIM_W'(cfg.top_limit);
    assign below_top = pos_lim < top_lim;

    // distance from backtrack start, exact in one extra bit
    assign diff = (POSITION_BITS + 1)'(position) - (POSITION_BITS + 1)'(origin_cur);
    assign travel = diff[POSITION_BITS] ? $unsigned(-diff) : $unsigned(diff);
    assign dist_reached = DIST_W'(travel) >= DIST_W'(cfg.backtrack_distance);

    assign timeout_cmp = TICK_W'(cfg.check_timeout);

    always_comb begin
        act         = action_cur;
        ticks       = ticks_cur;
        origin_next = origin_cur;
        speed       = '0;
        sol         = 1'b0;
        ticks_cmp   = TICK_W'(ticks_cur);
        case (mode)
            MODE_DOWN: begin
                speed = hung ? 16'sd0 : cfg.down_speed;
                act   = ACT_NONE;
            end
            MODE_UP: begin
                if (below_top && lock_up) begin
                    speed = cfg.up_speed;
                end
                sol = 1'b1;
                // start a check when the lock reads down
                if (!lock_up && act != ACT_CHECKING && act != ACT_DISENGAGING) begin
                    act   = ACT_CHECKING;
                    ticks = '0;
                end
                if (act == ACT_DISENGAGING) begin
                    sol   = 1'b0;
                    speed = cfg.backtrack_speed;
                    if (dist_reached) begin
                        act   = ACT_CHECKING;
                        ticks = '0;
                    end
                end
                ticks_cmp = TICK_W'(ticks);
                if (act == ACT_CHECKING) begin
                    sol   = 1'b1;
                    speed = '0;
                    if (lock_up) begin
                        act = ACT_KEEP_UP;
                    end else if (ticks_cmp > timeout_cmp) begin
                        act         = ACT_DISENGAGING;
                        origin_next = position;
                    end else if (ticks != '1) begin
                        ticks = ticks + TIMER_BITS'(1);
                    end
                end
            end
            MODE_STOP: begin
                act = ACT_NONE;
            end
            default: begin
                act = ACT_NONE;
            end
        endcase
        ticks_next         = ticks;
        result.motor_drive = speed;
        result.solenoid_on = sol;
        result.action      = act;
    end

endmodule

`default_nettype wire

// ----- design/ratchet_lift_sequencer.sv -----
// ----------------------------------------------------------------------------
// ratchet_lift_sequencer: lift motor and ratchet lock sequencer
// Pipeline: a request is accepted into the input register, then its result
//   goes into the result register; throughput one request per cycle while the
//   result side is not stalled, set by the single pass of compare and subtract
//   logic between the two registers.
// Reset: aresetn low clears both valid flags, the lock action (none), the
//   check timer, the backtrack origin and all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ratchet_lift_sequencer
    import rls_pkg::*;
#(
    parameter int POSITION_BITS = RLS_POSITION_BITS,
    parameter int TIMER_BITS    = RLS_TIMER_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic        [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic        [CFG_DATA_BITS-1:0]  cfg_data,
    // request channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic        [1:0]               s_mode,
    input  wire logic                            s_hung,
    input  wire logic                            s_lock_up,
    input  wire logic signed [POSITION_BITS-1:0] s_position,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed      [15:0]              m_motor_drive,
    output logic                                 m_solenoid_on,
    output logic             [1:0]               m_action
);

    // configuration
    rls_cfg_t                      cfg_reg;
    rls_cfg_t                      cfg_next;

    // input register stage
    logic                          in_valid_reg;
    logic        [1:0]             mode_reg;
    logic                          hung_reg;
    logic                          lock_up_reg;
    logic signed [POSITION_BITS-1:0] position_reg;

    // lock sequencer state
    rls_action_t                   action_reg;
    logic        [TIMER_BITS-1:0]  ticks_reg;
    logic signed [POSITION_BITS-1:0] origin_reg;

    // result register stage
    logic                          m_valid_reg;
    rls_result_t                   result_reg;

    rls_result_t                   result_next;
    logic        [TIMER_BITS-1:0]  ticks_next;
    logic signed [POSITION_BITS-1:0] origin_next;

    logic                          s_take;
    logic                          out_free;
    logic                          advance;

    // Advance the input stage whenever the result register is empty or being
    // drained this cycle; the input register refills in the same cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign s_take   = s_valid && s_ready;

    // The user must write registers only while idle; the block itself does not enforce this, so always take the write.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_DOWN_SPEED:         cfg_next.down_speed         = cfg_data[15:0];
                CFG_UP_SPEED:           cfg_next.up_speed           = cfg_data[15:0];
                CFG_BACKTRACK_SPEED:    cfg_next.backtrack_speed    = cfg_data[15:0];
                CFG_TOP_LIMIT:          cfg_next.top_limit          = cfg_data[31:0];
                CFG_BACKTRACK_DISTANCE: cfg_next.backtrack_distance = cfg_data[30:0];
                CFG_CHECK_TIMEOUT:      cfg_next.check_timeout      = cfg_data[15:0];
                default:                cfg_next = cfg_reg;  // drop writes past the map
            endcase
        end
    end

    // One control period worth of decisions from the held request and state.
    rls_step #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_step (
        .mode        (mode_reg),
        .hung        (hung_reg),
        .lock_up     (lock_up_reg),
        .position    (position_reg),
        .cfg         (cfg_reg),
        .action_cur  (action_reg),
        .ticks_cur   (ticks_reg),
        .origin_cur  (origin_reg),
        .result      (result_next),
        .ticks_next  (ticks_next),
        .origin_next (origin_next)
    );

    // Control state, configuration and sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cfg_reg      <= '0;
            action_reg   <= ACT_NONE;
            ticks_reg    <= '0;
            origin_reg   <= '0;
        end else begin
            cfg_reg <= cfg_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
            // commit the state only when the request moves into the result stage
            if (advance) begin
                action_reg <= result_next.action;
                ticks_reg  <= ticks_next;
                origin_reg <= origin_next;
            end
        end
    end

    // Payload registers: hold until the stage advances.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            mode_reg     <= s_mode;
            hung_reg     <= s_hung;
            lock_up_reg  <= s_lock_up;
            position_reg <= s_position;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_motor_drive = result_reg.motor_drive;
    assign m_solenoid_on = result_reg.solenoid_on;
    assign m_action      = result_reg.action;

endmodule

`default_nettype wire

// ----- design/rls_checker.sv -----
// ----------------------------------------------------------------------------
// rls_checker: port-level checks of the ratchet lift sequencer
// Reset, flow control and result consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_checker
    import rls_pkg::*;
(
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic signed [15:0]              m_motor_drive,
    input wire logic                            m_solenoid_on,
    input wire logic        [1:0]               m_action
);

    // reset empties the result stage
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a draining result stage never stalls the request side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("request stalled while result side ready");

    // keep up always drives the lock up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_KEEP_UP) |-> m_solenoid_on)
        else $error("keep up without solenoid drive");

    // checking holds the motor and drives the lock up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_CHECKING) |-> (m_solenoid_on && m_motor_drive == 16'sd0))
        else $error("checking with motor running or solenoid off");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_motor_drive) && $stable(m_action)
            && $stable(m_solenoid_on)))
        else $error("stalled result changed");

endmodule

bind ratchet_lift_sequencer rls_checker u_rls_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_motor_drive (m_motor_drive),
    .m_solenoid_on (m_solenoid_on),
    .m_action      (m_action)
);

`default_nettype wire
